/* design/tmd_pkg.sv */
package tmd_pkg;

	// Header layout: position of the high length byte in each mode.
	localparam logic [15:0] LEN_POS_ID   = 16'd5;
	localparam logic [15:0] LEN_POS_NOID = 16'd1;

	// Position of the type byte, which opens every header.
	localparam logic [15:0] KIND_POS     = 16'd0;

	typedef enum logic {
		PH_HEADER  = 1'b0,
		PH_PAYLOAD = 1'b1
	} tmd_phase_t;

	// Parser state carried from one beat to the next.
	typedef struct packed {
		tmd_phase_t  phase;
		logic [15:0] pos;
		logic [7:0]  kind;
		logic [31:0] ident;
		logic [15:0] length;
	} tmd_state_t;

	// One result beat.
	typedef struct packed {
		logic [7:0]  msg_kind;
		logic [31:0] msg_ident;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
		logic        has_data;
		logic        last_of_msg;
	} tmd_result_t;

	localparam tmd_state_t STATE_CLEAR = '{
		phase:  PH_HEADER,
		pos:    16'd0,
		kind:   8'd0,
		ident:  32'd0,
		length: 16'd0
	};

endpackage

/* design/tmd_in_if.sv */
interface tmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

/* design/tmd_out_if.sv */
interface tmd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  msg_kind;
	logic [31:0] msg_ident;
	logic [15:0] payload_length;
	logic [7:0]  payload_byte;
	logic        has_data;
	logic        last_of_msg;

	modport source (
		output valid, output msg_kind, output msg_ident, output payload_length,
		output payload_byte, output has_data, output last_of_msg,
		input ready
	);
	modport sink (
		input valid, input msg_kind, input msg_ident, input payload_length,
		input payload_byte, input has_data, input last_of_msg,
		output ready
	);
endinterface

/* design/typed_message_deframer_core.sv */
// Typed message deframer.
// in_ch carries the raw stream, one byte per beat. Each message is a type
// byte, an optional four-byte big-endian id (present while id_mode is 1),
// a two-byte big-endian payload length, then that many payload bytes.
// out_ch carries one beat per payload byte with the header fields, the
// final byte of a message marked last_of_msg. A message of length zero
// gives one beat with has_data low when its last header byte arrives.
// cfg_we/cfg_wdata write id_mode; write it only while the block is idle.
// Throughput is one byte per cycle while in_ch.ready is high: the parser
// updates its state in the same cycle a byte is taken. Each result reaches
// out_ch through the registered output stage. Other header bytes give no beat.
// The output side is an output register backed by one skid entry, so a
// stalled receiver does not stop the byte that is already in flight;
// in_ch.ready drops only while the skid entry is occupied and returns the
// cycle after the receiver takes a beat.
// Reset clears the parser to the start of a header, empties the output
// stage and sets id_mode to 1.
module typed_message_deframer_core (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	tmd_in_if.sink    in_ch,
	tmd_out_if.source out_ch
);

	logic                 id_mode_q;
	tmd_pkg::tmd_state_t  state_q;
	tmd_pkg::tmd_state_t  state_nxt;
	tmd_pkg::tmd_result_t res;
	logic                 emit;
	tmd_pkg::tmd_result_t main_q;
	tmd_pkg::tmd_result_t skid_q;
	logic                 main_v_q;
	logic                 skid_v_q;
	logic                 accept;
	logic                 push;
	logic                 pop;

	assign in_ch.ready = ~skid_v_q;
	assign accept      = in_ch.valid & ~skid_v_q;
	assign push        = accept & emit;
	assign pop         = main_v_q & out_ch.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_mode_q <= 1'b1;
		end else if (cfg_we) begin
			id_mode_q <= cfg_wdata;
		end
	end

	tmd_step u_step (
		.cur     (state_q),
		.id_mode (id_mode_q),
		.in_byte (in_ch.in_byte),
		.nxt     (state_nxt),
		.res     (res),
		.emit    (emit)
	);

	// Parser state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmd_pkg::STATE_CLEAR;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output register and skid entry valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	// Output register and skid entry payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= res;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_q <= res;
			end else begin
				main_q <= res;
			end
		end
	end

	assign out_ch.valid          = main_v_q;
	assign out_ch.msg_kind       = main_q.msg_kind;
	assign out_ch.msg_ident      = main_q.msg_ident;
	assign out_ch.payload_length = main_q.payload_length;
	assign out_ch.payload_byte   = main_q.payload_byte;
	assign out_ch.has_data       = main_q.has_data;
	assign out_ch.last_of_msg    = main_q.last_of_msg;

endmodule

/* design/tmd_step.sv */
module tmd_step (
	input  tmd_pkg::tmd_state_t  cur,
	input  logic                 id_mode,
	input  logic [7:0]           in_byte,
	output tmd_pkg::tmd_state_t  nxt,
	output tmd_pkg::tmd_result_t res,
	output logic                 emit
);

	logic [15:0] len_pos;
	logic [15:0] len_full;
	logic        pay_last;

	// Header layout depends on whether the id field is present.
	assign len_pos  = id_mode ? tmd_pkg::LEN_POS_ID : tmd_pkg::LEN_POS_NOID;
	// Length as it reads once the low length byte is merged in.
	assign len_full = {cur.length[15:8], in_byte};
	// The current payload byte closes the message.
	assign pay_last = ({1'b0, cur.pos} + 17'd1) >= {1'b0, cur.length};

	// Next state of the parser.
	always_comb begin
		nxt = cur;
		case (cur.phase)
			tmd_pkg::PH_HEADER: begin
				if (cur.pos == tmd_pkg::KIND_POS) begin
					nxt.kind   = in_byte;
					nxt.ident  = 32'd0;
					nxt.length = 16'd0;
					nxt.pos    = cur.pos + 16'd1;
				end else if (cur.pos < len_pos) begin
					nxt.ident = {cur.ident[23:0], in_byte};
					nxt.pos   = cur.pos + 16'd1;
				end else if (cur.pos == len_pos) begin
					nxt.length = {in_byte, 8'd0};
					nxt.pos    = cur.pos + 16'd1;
				end else if (len_full == 16'd0) begin
					nxt = tmd_pkg::STATE_CLEAR;
				end else begin
					nxt.length = len_full;
					nxt.phase  = tmd_pkg::PH_PAYLOAD;
					nxt.pos    = 16'd0;
				end
			end
			tmd_pkg::PH_PAYLOAD: begin
				if (pay_last) begin
					nxt = tmd_pkg::STATE_CLEAR;
				end else begin
					nxt.pos = cur.pos + 16'd1;
				end
			end
			default: begin
				nxt = tmd_pkg::STATE_CLEAR;
			end
		endcase
	end

	// Result beat for this byte, if any.
	always_comb begin
		res.msg_kind       = cur.kind;
		res.msg_ident      = id_mode ? cur.ident : 32'd0;
		res.payload_length = cur.length;
		res.payload_byte   = 8'd0;
		res.has_data       = 1'b0;
		res.last_of_msg    = 1'b0;
		emit               = 1'b0;
		case (cur.phase)
			tmd_pkg::PH_HEADER: begin
				if (cur.pos != tmd_pkg::KIND_POS && cur.pos > len_pos
						&& len_full == 16'd0) begin
					res.payload_length = 16'd0;
					res.last_of_msg    = 1'b1;
					emit               = 1'b1;
				end
			end
			tmd_pkg::PH_PAYLOAD: begin
				res.payload_byte = in_byte;
				res.has_data     = 1'b1;
				res.last_of_msg  = pay_last;
				emit             = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

endmodule

/* design/tmd_checker.sv */
module tmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  msg_kind,
	input logic [31:0] msg_ident,
	input logic [15:0] payload_length,
	input logic [7:0]  payload_byte,
	input logic        has_data,
	input logic        last_of_msg
);

	// A stalled result beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({msg_kind, msg_ident, payload_length, payload_byte,
				has_data, last_of_msg}))
		else $error("result beat changed while stalled");

	// An empty message is a single final beat with zero length and data.
	a_empty_msg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> last_of_msg && payload_length == 16'd0
			&& payload_byte == 8'd0)
		else $error("malformed empty message beat");

	// The input stalls only while a result is waiting behind a full output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

	// A new result appears only right after an input beat was taken.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result beat without an accepted input beat");

endmodule

bind typed_message_deframer_core tmd_checker u_tmd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.msg_kind       (out_ch.msg_kind),
	.msg_ident      (out_ch.msg_ident),
	.payload_length (out_ch.payload_length),
	.payload_byte   (out_ch.payload_byte),
	.has_data       (out_ch.has_data),
	.last_of_msg    (out_ch.last_of_msg)
);
